// File: rtl/core/lsclip_pkg.sv
// Package for the line segment window clipper: region code bits, round count,
// window struct and the region code function. Depends on nothing.
package lsclip_pkg;

    // Widest internal coordinate for any legal COORD_BITS (24 + 2).
    localparam int MAX_W = 26;

    // Clipping rounds built as pipeline sections.
    localparam int ROUNDS = 4;

    localparam logic [3:0] CODE_LEFT  = 4'd1;
    localparam logic [3:0] CODE_RIGHT = 4'd2;
    localparam logic [3:0] CODE_BELOW = 4'd4;
    localparam logic [3:0] CODE_ABOVE = 4'd8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_BOTTOM = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;
    localparam logic [1:0] REG_HEIGHT = 2'd3;

    typedef struct packed {
        logic signed [MAX_W-1:0] xlo;
        logic signed [MAX_W-1:0] ylo;
        logic signed [MAX_W-1:0] xhi;
        logic signed [MAX_W-1:0] yhi;
    } win_t;

    function automatic logic [3:0] region_code(input logic signed [MAX_W-1:0] x,
                                               input logic signed [MAX_W-1:0] y,
                                               input win_t w);
        logic [3:0] c;
        c = 4'd0;
        if (x < w.xlo) begin
            c = c | CODE_LEFT;
        end else if (x > w.xhi) begin
            c = c | CODE_RIGHT;
        end
        if (y < w.ylo) begin
            c = c | CODE_BELOW;
        end else if (y > w.yhi) begin
            c = c | CODE_ABOVE;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/lsclip_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Depends on nothing; used by lsclip_round.
module lsclip_divider #(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 18,
    parameter int Q_W    = 18,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [Q_W-1:0]    quot,
    output logic [SIDE_W-1:0] side_out
);
    localparam int T_W = NUM_W + 1;

    logic              v_reg    [0:Q_W];
    logic [NUM_W-1:0]  rem_reg  [0:Q_W];
    logic [DEN_W-1:0]  den_reg  [0:Q_W];
    logic [Q_W-1:0]    q_reg    [0:Q_W];
    logic [SIDE_W-1:0] side_reg [0:Q_W];

    always_comb begin
        v_reg[0]    = in_valid;
        rem_reg[0]  = num;
        den_reg[0]  = den;
        q_reg[0]    = '0;
        side_reg[0] = side_in;
    end

    genvar i;
    generate
        for (i = 0; i < Q_W; i++) begin : g_stage
            localparam int BIT = Q_W - 1 - i;
            logic [T_W-1:0] trial;
            logic           take;
            logic [Q_W-1:0] q_next;
            logic [NUM_W-1:0] rem_next;

            always_comb begin
                trial    = T_W'(den_reg[i]) << BIT;
                take     = T_W'(rem_reg[i]) >= trial;
                q_next   = q_reg[i];
                q_next[BIT] = take;
                rem_next = take ? NUM_W'(T_W'(rem_reg[i]) - trial) : rem_reg[i];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[i+1] <= 1'b0;
                end else if (adv) begin
                    v_reg[i+1] <= v_reg[i];
                end
            end

            always_ff @(posedge aclk) begin
                if (adv) begin
                    rem_reg[i+1]  <= rem_next;
                    den_reg[i+1]  <= den_reg[i];
                    q_reg[i+1]    <= q_next;
                    side_reg[i+1] <= side_reg[i];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign side_out  = side_reg[Q_W];

endmodule

// File: rtl/core/lsclip_round.sv
// One clipping round: decide, set up operands, multiply, divide, move endpoint.
// Depends on lsclip_pkg and lsclip_divider.
module lsclip_round #(
    parameter int P     = 18,
    parameter int TAG_W = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  lsclip_pkg::win_t     win,
    input  logic                 in_valid,
    input  logic signed [P-1:0]  in_xa,
    input  logic signed [P-1:0]  in_ya,
    input  logic signed [P-1:0]  in_xb,
    input  logic signed [P-1:0]  in_yb,
    input  logic [3:0]           in_ca,
    input  logic [3:0]           in_cb,
    input  logic                 in_done,
    input  logic                 in_vis,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic signed [P-1:0]  out_xa,
    output logic signed [P-1:0]  out_ya,
    output logic signed [P-1:0]  out_xb,
    output logic signed [P-1:0]  out_yb,
    output logic [3:0]           out_ca,
    output logic [3:0]           out_cb,
    output logic                 out_done,
    output logic                 out_vis,
    output logic [TAG_W-1:0]     out_tag
);
    import lsclip_pkg::*;

    localparam int D_W    = P + 1;
    localparam int M_W    = 2 * D_W;
    localparam int ST_W   = 4 * P + 8 + 2 + TAG_W;
    localparam int SIDE_W = ST_W + 2 * P + 5;

    // Stage 1: decide and select operands
    logic              dec_done, dec_vis, dec_act, dec_sel_a, dec_axis_y;
    logic [3:0]        dec_pick;
    logic signed [P-1:0]   dec_edge, dec_base;
    logic signed [D_W-1:0] dec_d1, dec_d2, dec_dn;

    always_comb begin
        dec_done   = in_done || ((in_ca | in_cb) == 4'd0) || ((in_ca & in_cb) != 4'd0);
        dec_vis    = in_done ? in_vis : ((in_ca | in_cb) == 4'd0);
        dec_act    = !dec_done;
        dec_sel_a  = in_ca >= in_cb;
        dec_pick   = dec_sel_a ? in_ca : in_cb;
        if ((dec_pick & CODE_ABOVE) != 4'd0) begin
            dec_edge   = P'(win.yhi);
            dec_axis_y = 1'b1;
        end else if ((dec_pick & CODE_BELOW) != 4'd0) begin
            dec_edge   = P'(win.ylo);
            dec_axis_y = 1'b1;
        end else if ((dec_pick & CODE_RIGHT) != 4'd0) begin
            dec_edge   = P'(win.xhi);
            dec_axis_y = 1'b0;
        end else begin
            dec_edge   = P'(win.xlo);
            dec_axis_y = 1'b0;
        end
        if (dec_axis_y) begin
            dec_d1   = D_W'(in_xb) - D_W'(in_xa);
            dec_d2   = D_W'(dec_edge) - D_W'(in_ya);
            dec_dn   = D_W'(in_yb) - D_W'(in_ya);
            dec_base = in_xa;
        end else begin
            dec_d1   = D_W'(in_yb) - D_W'(in_ya);
            dec_d2   = D_W'(dec_edge) - D_W'(in_xa);
            dec_dn   = D_W'(in_xb) - D_W'(in_xa);
            dec_base = in_ya;
        end
    end

    logic                  s1_valid_reg;
    logic [ST_W-1:0]       s1_st_reg;
    logic signed [D_W-1:0] s1_d1_reg, s1_d2_reg, s1_dn_reg;
    logic signed [P-1:0]   s1_edge_reg, s1_base_reg;
    logic                  s1_act_reg, s1_sel_a_reg, s1_axis_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_st_reg     <= {in_xa, in_ya, in_xb, in_yb, in_ca, in_cb,
                              dec_done, dec_vis, in_tag};
            s1_d1_reg     <= dec_d1;
            s1_d2_reg     <= dec_d2;
            s1_dn_reg     <= dec_dn;
            s1_edge_reg   <= dec_edge;
            s1_base_reg   <= dec_base;
            s1_act_reg    <= dec_act;
            s1_sel_a_reg  <= dec_sel_a;
            s1_axis_y_reg <= dec_axis_y;
        end
    end

    // Stage 2: multiply
    logic                  s2_valid_reg;
    logic [ST_W-1:0]       s2_st_reg;
    logic signed [M_W-1:0] s2_prod_reg;
    logic signed [D_W-1:0] s2_dn_reg;
    logic signed [P-1:0]   s2_edge_reg, s2_base_reg;
    logic                  s2_act_reg, s2_sel_a_reg, s2_axis_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s2_st_reg     <= s1_st_reg;
            s2_prod_reg   <= M_W'(s1_d1_reg) * M_W'(s1_d2_reg);
            s2_dn_reg     <= s1_dn_reg;
            s2_edge_reg   <= s1_edge_reg;
            s2_base_reg   <= s1_base_reg;
            s2_act_reg    <= s1_act_reg;
            s2_sel_a_reg  <= s1_sel_a_reg;
            s2_axis_y_reg <= s1_axis_y_reg;
        end
    end

    // Stage 3: magnitudes and quotient sign
    logic                  s3_valid_reg;
    logic [M_W-1:0]        s3_num_reg;
    logic [D_W-1:0]        s3_den_reg;
    logic [SIDE_W-1:0]     s3_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (adv) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s3_num_reg  <= s2_prod_reg[M_W-1] ? M_W'(-s2_prod_reg) : M_W'(s2_prod_reg);
            s3_den_reg  <= s2_dn_reg[D_W-1] ? D_W'(-s2_dn_reg) : D_W'(s2_dn_reg);
            s3_side_reg <= {s2_st_reg, s2_edge_reg, s2_base_reg, s2_act_reg,
                            s2_sel_a_reg, s2_axis_y_reg,
                            s2_prod_reg[M_W-1] ^ s2_dn_reg[D_W-1],
                            s2_dn_reg == '0};
        end
    end

    // Divider stages
    logic              dv_valid;
    logic [D_W-1:0]    dv_quot;
    logic [SIDE_W-1:0] dv_side;

    lsclip_divider #(
        .NUM_W  (M_W),
        .DEN_W  (D_W),
        .Q_W    (D_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .num       (s3_num_reg),
        .den       (s3_den_reg),
        .side_in   (s3_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // Final stage: apply quotient, move the chosen endpoint, recode
    logic signed [P-1:0]   f_xa, f_ya, f_xb, f_yb, f_edge, f_base, f_v;
    logic [3:0]            f_ca, f_cb;
    logic                  f_done, f_vis, f_act, f_sel_a, f_axis_y, f_neg, f_dz;
    logic [TAG_W-1:0]      f_tag;
    logic signed [D_W-1:0] f_q, f_sum;
    logic signed [P-1:0]   f_nx, f_ny;

    always_comb begin
        {f_xa, f_ya, f_xb, f_yb, f_ca, f_cb, f_done, f_vis, f_tag,
         f_edge, f_base, f_act, f_sel_a, f_axis_y, f_neg, f_dz} = dv_side;
        if (f_dz) begin
            f_q = '0;
        end else if (f_neg) begin
            f_q = -$signed(dv_quot);
        end else begin
            f_q = $signed(dv_quot);
        end
        f_sum = D_W'(f_base) + f_q;
        f_v   = f_sum[P-1:0];
        f_nx  = f_axis_y ? f_v : f_edge;
        f_ny  = f_axis_y ? f_edge : f_v;
        if (f_act && f_sel_a) begin
            f_xa = f_nx;
            f_ya = f_ny;
            f_ca = region_code(MAX_W'(f_nx), MAX_W'(f_ny), win);
        end else if (f_act) begin
            f_xb = f_nx;
            f_yb = f_ny;
            f_cb = region_code(MAX_W'(f_nx), MAX_W'(f_ny), win);
        end
    end

    logic out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_xa   <= f_xa;
            out_ya   <= f_ya;
            out_xb   <= f_xb;
            out_yb   <= f_yb;
            out_ca   <= f_ca;
            out_cb   <= f_cb;
            out_done <= f_done;
            out_vis  <= f_vis;
            out_tag  <= f_tag;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/line_segment_window_clipper_unit.sv
// Top level of the line segment window clipper: window registers, input coding,
// clipping rounds and the output register. Depends on lsclip_pkg, lsclip_round.
//
//  channel  ports                                   width (COORD_BITS = C)
//  s_       s_valid/s_ready, start/end x y, color   4 x C signed, 32
//  m_       m_valid/m_ready, visible, clipped x y   1, 4 x (C+1) signed, 32
//  cfg_     cfg_wen, cfg_index, cfg_wdata           2, C
//
// One segment enters per cycle unless a stall at m_ holds the pipeline; the path
// runs through four rounds of multiply and a one-bit-per-stage divider.
// Reset (aresetn low, synchronous) clears all valid bits and the window.
// A stall at m_ holds the whole pipeline; s_ready follows it in the same cycle.
module line_segment_window_clipper_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wen,
    input  logic [1:0]                   cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic [31:0]                  s_color_in,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_visible,
    output logic signed [COORD_BITS:0]   m_clipped_start_x,
    output logic signed [COORD_BITS:0]   m_clipped_start_y,
    output logic signed [COORD_BITS:0]   m_clipped_end_x,
    output logic signed [COORD_BITS:0]   m_clipped_end_y,
    output logic [31:0]                  m_color_out
);
    import lsclip_pkg::*;

    localparam int P = COORD_BITS + 2;

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    logic signed [COORD_BITS-1:0] left_reg, bottom_reg;
    logic [COORD_BITS-2:0]        width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= '0;
            bottom_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_LEFT:   left_reg   <= cfg_wdata;
                REG_BOTTOM: bottom_reg <= cfg_wdata;
                REG_WIDTH:  width_reg  <= cfg_wdata[COORD_BITS-2:0];
                REG_HEIGHT: height_reg <= cfg_wdata[COORD_BITS-2:0];
                default: ;
            endcase
        end
    end

    win_t win;
    always_comb begin
        win.xlo = MAX_W'(left_reg);
        win.ylo = MAX_W'(bottom_reg);
        win.xhi = MAX_W'(left_reg) + MAX_W'(width_reg);
        win.yhi = MAX_W'(bottom_reg) + MAX_W'(height_reg);
    end

    logic                v_w    [0:ROUNDS];
    logic signed [P-1:0] xa_w   [0:ROUNDS];
    logic signed [P-1:0] ya_w   [0:ROUNDS];
    logic signed [P-1:0] xb_w   [0:ROUNDS];
    logic signed [P-1:0] yb_w   [0:ROUNDS];
    logic [3:0]          ca_w   [0:ROUNDS];
    logic [3:0]          cb_w   [0:ROUNDS];
    logic                done_w [0:ROUNDS];
    logic                vis_w  [0:ROUNDS];
    logic [31:0]         tag_w  [0:ROUNDS];

    // Input stage: widen coordinates and code both endpoints
    logic                in_valid_reg;
    logic signed [P-1:0] in_xa_reg, in_ya_reg, in_xb_reg, in_yb_reg;
    logic [3:0]          in_ca_reg, in_cb_reg;
    logic [31:0]         in_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_xa_reg  <= P'(s_start_x);
            in_ya_reg  <= P'(s_start_y);
            in_xb_reg  <= P'(s_end_x);
            in_yb_reg  <= P'(s_end_y);
            in_ca_reg  <= region_code(MAX_W'(s_start_x), MAX_W'(s_start_y), win);
            in_cb_reg  <= region_code(MAX_W'(s_end_x), MAX_W'(s_end_y), win);
            in_tag_reg <= s_color_in;
        end
    end

    always_comb begin
        v_w[0]    = in_valid_reg;
        xa_w[0]   = in_xa_reg;
        ya_w[0]   = in_ya_reg;
        xb_w[0]   = in_xb_reg;
        yb_w[0]   = in_yb_reg;
        ca_w[0]   = in_ca_reg;
        cb_w[0]   = in_cb_reg;
        done_w[0] = 1'b0;
        vis_w[0]  = 1'b0;
        tag_w[0]  = in_tag_reg;
    end

    genvar r;
    generate
        for (r = 0; r < ROUNDS; r++) begin : g_round
            lsclip_round #(
                .P     (P),
                .TAG_W (32)
            ) u_round (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .adv       (adv),
                .win       (win),
                .in_valid  (v_w[r]),
                .in_xa     (xa_w[r]),
                .in_ya     (ya_w[r]),
                .in_xb     (xb_w[r]),
                .in_yb     (yb_w[r]),
                .in_ca     (ca_w[r]),
                .in_cb     (cb_w[r]),
                .in_done   (done_w[r]),
                .in_vis    (vis_w[r]),
                .in_tag    (tag_w[r]),
                .out_valid (v_w[r+1]),
                .out_xa    (xa_w[r+1]),
                .out_ya    (ya_w[r+1]),
                .out_xb    (xb_w[r+1]),
                .out_yb    (yb_w[r+1]),
                .out_ca    (ca_w[r+1]),
                .out_cb    (cb_w[r+1]),
                .out_done  (done_w[r+1]),
                .out_vis   (vis_w[r+1]),
                .out_tag   (tag_w[r+1])
            );
        end
    endgenerate

    // Output register: settle any segment still open after the last round
    logic fin_vis;
    assign fin_vis = done_w[ROUNDS] ? vis_w[ROUNDS]
                                    : ((ca_w[ROUNDS] | cb_w[ROUNDS]) == 4'd0);

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_w[ROUNDS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_visible         <= fin_vis;
            m_clipped_start_x <= fin_vis ? xa_w[ROUNDS][COORD_BITS:0] : '0;
            m_clipped_start_y <= fin_vis ? ya_w[ROUNDS][COORD_BITS:0] : '0;
            m_clipped_end_x   <= fin_vis ? xb_w[ROUNDS][COORD_BITS:0] : '0;
            m_clipped_end_y   <= fin_vis ? yb_w[ROUNDS][COORD_BITS:0] : '0;
            m_color_out       <= tag_w[ROUNDS];
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: sim/tb_line_segment_window_clipper_unit.sv
// Testbench for line_segment_window_clipper_unit: random and directed segments
// checked against an in-bench Cohen-Sutherland predictor. Depends on lsclip_pkg.
`timescale 1ns / 100ps

module tb_line_segment_window_clipper_unit;
    import lsclip_pkg::*;

    localparam int C          = 16;
    localparam int LATENCY    = 4 * (C + 7) + 2;
    localparam int CYCLE_CAP  = 600000;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic signed [C-1:0] sx, sy, ex, ey;
        logic [31:0]         color;
    } segment_t;

    typedef struct {
        logic                visible;
        logic signed [C:0]   sx, sy, ex, ey;
        logic [31:0]         color;
    } clip_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wen = 1'b0;
    logic [1:0] cfg_index = REG_LEFT;
    logic [C-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [C-1:0] s_start_x = '0, s_start_y = '0, s_end_x = '0, s_end_y = '0;
    logic [31:0] s_color_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_visible;
    logic signed [C:0] m_clipped_start_x, m_clipped_start_y;
    logic signed [C:0] m_clipped_end_x, m_clipped_end_y;
    logic [31:0] m_color_out;

    line_segment_window_clipper_unit #(.COORD_BITS(C)) dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // window copy kept by the predictor
    logic signed [C-1:0] win_left = '0, win_bottom = '0;
    logic [C-2:0]        win_width = '0, win_height = '0;

    segment_t pending_segs[$];
    clip_t    expected_clips[$];
    int       errors = 0;
    int       cycles = 0;
    bit       send_idle = 1'b1, recv_idle = 1'b1;
    bit       long_req = 1'b0, long_done = 1'b0;
    int       send_gap = 0, recv_stall = 0;

    function automatic logic [3:0] outcode(longint x, longint y, longint xl, longint yl,
                                           longint xh, longint yh);
        logic [3:0] c;
        c = 4'd0;
        if (x < xl) c |= CODE_LEFT;
        else if (x > xh) c |= CODE_RIGHT;
        if (y < yl) c |= CODE_BELOW;
        else if (y > yh) c |= CODE_ABOVE;
        return c;
    endfunction

    function automatic longint tdiv(longint n, longint d);
        return (d == 0) ? 0 : n / d;
    endfunction

    function automatic clip_t clip_segment(segment_t s);
        longint xa, ya, xb, yb, xl, yl, xh, yh, nx, ny;
        logic [3:0] ca, cb, pick;
        bit vis;
        clip_t r;
        xa = s.sx; ya = s.sy; xb = s.ex; yb = s.ey;
        xl = win_left; yl = win_bottom;
        xh = xl + longint'(win_width);
        yh = yl + longint'(win_height);
        ca = outcode(xa, ya, xl, yl, xh, yh);
        cb = outcode(xb, yb, xl, yl, xh, yh);
        vis = 1'b0;
        for (int round = 0; round <= 8; round++) begin
            if ((ca | cb) == 4'd0) begin
                vis = 1'b1;
                break;
            end
            if ((ca & cb) != 4'd0 || round == 8) break;
            pick = (ca > cb) ? ca : cb;
            if (pick & CODE_ABOVE) begin
                nx = xa + tdiv((xb - xa) * (yh - ya), yb - ya);
                ny = yh;
            end else if (pick & CODE_BELOW) begin
                nx = xa + tdiv((xb - xa) * (yl - ya), yb - ya);
                ny = yl;
            end else if (pick & CODE_RIGHT) begin
                ny = ya + tdiv((yb - ya) * (xh - xa), xb - xa);
                nx = xh;
            end else begin
                ny = ya + tdiv((yb - ya) * (xl - xa), xb - xa);
                nx = xl;
            end
            if (pick == ca) begin
                xa = nx; ya = ny;
                ca = outcode(xa, ya, xl, yl, xh, yh);
            end else begin
                xb = nx; yb = ny;
                cb = outcode(xb, yb, xl, yl, xh, yh);
            end
        end
        r.visible = vis;
        r.sx = vis ? xa[C:0] : '0;
        r.sy = vis ? ya[C:0] : '0;
        r.ex = vis ? xb[C:0] : '0;
        r.ey = vis ? yb[C:0] : '0;
        r.color = s.color;
        return r;
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
    end

    // driver: record accepted beats, then offer the next pending segment
    always @(posedge aclk) begin
        segment_t seg;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_clips.push_back(clip_segment('{s_start_x, s_start_y,
                                                        s_end_x, s_end_y, s_color_in}));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_segs.size() > 0) begin
                    seg = pending_segs.pop_front();
                    s_start_x <= seg.sx;
                    s_start_y <= seg.sy;
                    s_end_x <= seg.ex;
                    s_end_y <= seg.ey;
                    s_color_in <= seg.color;
                    s_valid <= 1'b1;
                    send_gap <= send_idle ? $urandom_range(0, 15) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result beat, then pick the next stall
    always @(posedge aclk) begin
        clip_t want;
        int nstall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            nstall = recv_stall;
            if (m_valid && m_ready) begin
                if (expected_clips.size() == 0) begin
                    $error("result beat with no segment outstanding");
                    errors++;
                end else begin
                    want = expected_clips.pop_front();
                    if (m_visible !== want.visible) begin
                        $error("visible: expected %0d, got %0d", want.visible, m_visible);
                        errors++;
                    end
                    if (m_clipped_start_x !== want.sx) begin
                        $error("clipped_start_x: expected %0d, got %0d",
                               want.sx, m_clipped_start_x);
                        errors++;
                    end
                    if (m_clipped_start_y !== want.sy) begin
                        $error("clipped_start_y: expected %0d, got %0d",
                               want.sy, m_clipped_start_y);
                        errors++;
                    end
                    if (m_clipped_end_x !== want.ex) begin
                        $error("clipped_end_x: expected %0d, got %0d",
                               want.ex, m_clipped_end_x);
                        errors++;
                    end
                    if (m_clipped_end_y !== want.ey) begin
                        $error("clipped_end_y: expected %0d, got %0d",
                               want.ey, m_clipped_end_y);
                        errors++;
                    end
                    if (m_color_out !== want.color) begin
                        $error("color_out: expected %h, got %h", want.color, m_color_out);
                        errors++;
                    end
                end
                if (long_req && !long_done) begin
                    nstall = LONG_HOLD;
                    long_done <= 1'b1;
                end else begin
                    nstall = recv_idle ? $urandom_range(0, 15) : 0;
                end
            end else if (nstall > 0) begin
                nstall = nstall - 1;
            end
            recv_stall <= nstall;
            m_ready <= (nstall == 0);
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [C-1:0] data);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_LEFT:   win_left = data;
            REG_BOTTOM: win_bottom = data;
            REG_WIDTH:  win_width = data[C-2:0];
            REG_HEIGHT: win_height = data[C-2:0];
            default: ;
        endcase
    endtask

    task automatic set_window(int l, int b, int w, int h);
        write_reg(REG_LEFT, l[C-1:0]);
        write_reg(REG_BOTTOM, b[C-1:0]);
        write_reg(REG_WIDTH, w[C-1:0]);
        write_reg(REG_HEIGHT, h[C-1:0]);
    endtask

    task automatic add_seg(int sx, int sy, int ex, int ey, logic [31:0] color);
        pending_segs.push_back('{sx[C-1:0], sy[C-1:0], ex[C-1:0], ey[C-1:0], color});
    endtask

    // hold until the block has drained, plus its latency
    task automatic drain();
        do @(negedge aclk);
        while (pending_segs.size() > 0 || s_valid || expected_clips.size() > 0);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    function automatic int near_coord(int lo, int span);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, 65535);
        return lo - span - 20 + $urandom_range(0, 3 * span + 40);
    endfunction

    task automatic random_phase(int count);
        int spx, spy;
        spx = win_width;
        spy = win_height;
        @(negedge aclk);
        for (int i = 0; i < count; i++)
            add_seg(near_coord(win_left, spx), near_coord(win_bottom, spy),
                    near_coord(win_left, spx), near_coord(win_bottom, spy), $urandom());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset window is the single point at the origin
        @(negedge aclk);
        add_seg(0, 0, 0, 0, 32'h0000_0000);
        add_seg(-1, 0, 1, 0, 32'hffff_ffff);
        add_seg(-32768, -32768, 32767, 32767, 32'h1234_5678);
        add_seg(32767, 32767, 32767, -32768, 32'h8765_4321);
        add_seg(-5, 3, 5, -3, 32'hdead_beef);
        drain();

        set_window(-100, -50, 200, 100);
        @(negedge aclk);
        add_seg(0, 0, 10, 10, 32'h0);
        add_seg(0, 0, 0, 200, 32'h1);
        add_seg(0, 0, 30, -300, 32'h2);
        add_seg(0, 0, 500, 20, 32'h3);
        add_seg(0, 0, -500, -20, 32'h4);
        add_seg(-300, -200, 300, 200, 32'h5);
        add_seg(-300, 0, -200, 10, 32'h6);
        add_seg(-200, 40, -80, 200, 32'h7);
        add_seg(100, -400, 100, 400, 32'h8);
        add_seg(32767, -32768, -32768, 32767, 32'hffff_ffff);
        add_seg(-100, -50, 100, 50, 32'ha5a5_5a5a);
        drain();

        // window extremes
        set_window(16'h8000, 16'h8000, 16'hffff, 16'h7fff);
        @(negedge aclk);
        add_seg(-32768, -32768, 32767, 32767, 32'h0);
        add_seg(32767, 0, -32768, 10, 32'h1);
        drain();
        set_window(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        @(negedge aclk);
        add_seg(-32768, -32768, 32767, 32767, 32'h2);
        add_seg(32767, 32767, 32767, 32767, 32'h3);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            send_idle = (ph % 3) != 1;
            recv_idle = (ph % 3) != 2;
            if (ph == 2) begin
                send_idle = 1'b0;
                long_req = 1'b1;
            end
            if (ph == 0)
                set_window(16'h8000, 16'h7fff, 16'h0000, 16'h0000);
            else
                set_window($urandom(), $urandom(), (ph % 2) ? $urandom_range(0, 64)
                           : $urandom(), (ph % 2) ? $urandom_range(0, 64) : $urandom());
            random_phase(245);
            drain();
        end

        if (errors == 0 && expected_clips.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
